/* src/double_ended_queue_core_macros.svh */
// ------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared immediate-implication and next-cycle property forms.
// ------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

/* src/deq_pkg.sv */
// ------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation and status codes, state type and ring arithmetic.
// ------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	localparam int VALUE_W  = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 5;
	localparam int EXT_W    = 64;

	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W   = ADDR_W + 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(DEPTH);
	localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] COUNT_BACK = COUNT_W'(DEPTH - 1);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_REAR  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// Position of an entry at a given offset from the head, wrapped once.
	function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] base,
		input logic [COUNT_W-1:0] offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

/* src/deq_if.sv */
// ------------------------------------------------------------------------
// Double-ended queue channels
// Valid/ready request and response channels with their payloads.
// ------------------------------------------------------------------------
interface deq_req_if;
	import deq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if;
	import deq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] popped_value;
	logic [STATUS_W-1:0]       status;
	logic [ENTRY_W-1:0]        entry_count;

	modport source (output valid, output popped_value, output status, output entry_count,
		input ready);
	modport sink   (input valid, input popped_value, input status, input entry_count,
		output ready);
endinterface

/* src/deq_ram.sv */
// ------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/double_ended_queue_core.sv */
// A push, or a pop of an empty queue, answers in the cycle after it is accepted;
// a pop that finds data answers after the READ state, which waits for the
// registered read of the ring memory. Throughput: one push per cycle while the
// response channel is not stalled; a pop that finds data holds the input in READ.
// Reset clears the head pointer, the count and the response valid at once;
// the memory contents are not cleared and are never read before written.
// ------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of words kept in a ring memory with a head and a count.
// ------------------------------------------------------------------------
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core (
	input logic     clk,
	input logic     arst_n,
	deq_req_if.sink req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	state_t                    state_q, state_d;
	logic [ADDR_W-1:0]         head_q, head_d;
	logic [COUNT_W-1:0]        count_q, count_d;
	status_t                   status_d;
	logic                      req_ready;
	logic                      in_fire;
	logic                      rsp_load_now;
	logic                      rsp_load_pop;
	logic                      pop_go;
	logic                      push_go;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [ADDR_W-1:0]         ram_raddr;
	logic [WORD_BITS-1:0]      ram_rdata;
	logic [EXT_W-1:0]          push_ext;
	logic [EXT_W-1:0]          pop_ext;
	logic [EXT_W-1:0]          cnt_ext;

	logic                      rsp_valid_q;
	logic signed [VALUE_W-1:0] rsp_popped_q;
	status_t                   rsp_status_q;
	logic [COUNT_W-1:0]        rsp_cnt_q;

	assign push_ext = EXT_W'($unsigned(req.value));
	assign pop_ext  = EXT_W'(ram_rdata);
	assign cnt_ext  = EXT_W'(rsp_cnt_q);

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req.ready = req_ready;
	assign in_fire   = req.valid && req_ready;

	assign pop_go  = in_fire && (count_q != '0) &&
		(req.operation == OP_POP_FRONT || req.operation == OP_POP_REAR);
	assign push_go = in_fire && (count_q != COUNT_MAX) &&
		(req.operation == OP_PUSH_REAR || req.operation == OP_PUSH_FRONT);

	deq_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(push_ext[WORD_BITS-1:0]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		status_d     = ST_DONE;
		ram_we       = 1'b0;
		ram_waddr    = head_q;
		ram_raddr    = head_q;
		rsp_load_now = 1'b0;
		rsp_load_pop = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (op_t'(req.operation))
						OP_PUSH_REAR: begin
							rsp_load_now = 1'b1;
							if (count_q == COUNT_MAX) begin
								status_d = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = ring_pos(head_q, count_q);
								count_d   = count_q + COUNT_ONE;
							end
						end
						OP_PUSH_FRONT: begin
							rsp_load_now = 1'b1;
							if (count_q == COUNT_MAX) begin
								status_d = ST_FULL;
							end else begin
								head_d    = ring_pos(head_q, COUNT_BACK);
								ram_we    = 1'b1;
								ram_waddr = head_d;
								count_d   = count_q + COUNT_ONE;
							end
						end
						OP_POP_FRONT: begin
							if (count_q == '0) begin
								status_d     = ST_EMPTY;
								rsp_load_now = 1'b1;
							end else begin
								ram_raddr = head_q;
								head_d    = ring_pos(head_q, COUNT_ONE);
								count_d   = count_q - COUNT_ONE;
								state_d   = S_READ;
							end
						end
						OP_POP_REAR: begin
							if (count_q == '0) begin
								status_d     = ST_EMPTY;
								rsp_load_now = 1'b1;
							end else begin
								ram_raddr = ring_pos(head_q, count_q - COUNT_ONE);
								count_d   = count_q - COUNT_ONE;
								state_d   = S_READ;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				state_d      = S_IDLE;
				rsp_load_pop = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (rsp_load_now || rsp_load_pop) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rsp_popped_q <= '0;
			rsp_status_q <= status_d;
			rsp_cnt_q    <= count_d;
		end
		if (rsp_load_pop) begin
			rsp_popped_q <= pop_ext[VALUE_W-1:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = rsp_popped_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.entry_count  = cnt_ext[ENTRY_W-1:0];

	`DEQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= COUNT_MAX)
	`DEQ_ASSERT_SAME(a_read_no_rsp, clk, arst_n, state_q == S_READ, !rsp_valid_q && !req_ready)
	`DEQ_ASSERT_NEXT(a_pop_reads, clk, arst_n, pop_go, state_q == S_READ)
	`DEQ_ASSERT_SAME(a_full_count, clk, arst_n, rsp_valid_q && rsp_status_q == ST_FULL, rsp_cnt_q == COUNT_MAX)
	`DEQ_ASSERT_NEXT(a_push_grows, clk, arst_n, push_go, count_q == $past(count_q) + COUNT_ONE)

endmodule

/* test/tb_double_ended_queue_core.sv */
// ------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push and pop requests at both ends of the deque through the
// valid/ready request channel, with random idle cycles on both sides, and
// checks every response against a ring-buffer predictor kept in step with
// each accepted request.
// ------------------------------------------------------------------------
module tb_double_ended_queue_core;
	import deq_pkg::*;

	typedef struct {
		logic signed [VALUE_W-1:0] popped_value;
		status_t                   status;
		logic [ENTRY_W-1:0]        entry_count;
	} deq_result_t;

	logic clk;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	logic [WORD_BITS-1:0] shadow_ring [DEPTH];
	int unsigned          shadow_head;
	int unsigned          shadow_count;

	deq_result_t pending_results [$];
	int          error_count;
	bit          idling_on;
	int          ready_hold_left;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic deq_result_t apply_deque_op(op_t op, logic signed [VALUE_W-1:0] word);
		deq_result_t res;
		res.popped_value = '0;
		res.status       = ST_DONE;
		case (op)
			OP_PUSH_REAR: begin
				if (shadow_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_ring[(shadow_head + shadow_count) % DEPTH] = word;
					shadow_count++;
				end
			end
			OP_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_ring[shadow_head] = word;
					shadow_count++;
				end
			end
			OP_POP_FRONT: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.popped_value = shadow_ring[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.popped_value = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
					shadow_count--;
				end
			end
		endcase
		res.entry_count = ENTRY_W'(shadow_count);
		return res;
	endfunction

	task automatic send_request(op_t op, logic signed [VALUE_W-1:0] word);
		while (idling_on && $urandom_range(99) < 18) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.value     <= word;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		pending_results.push_back(apply_deque_op(op, word));
	endtask

	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_word();
		case ($urandom_range(15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(int unsigned push_pct);
		if ($urandom_range(99) < push_pct) begin
			return $urandom_range(1) ? op_t'(OP_PUSH_FRONT) : op_t'(OP_PUSH_REAR);
		end
		return $urandom_range(1) ? op_t'(OP_POP_FRONT) : op_t'(OP_POP_REAR);
	endfunction

	task automatic test_empty_pops();
		send_request(OP_POP_FRONT, 32'sh7fff_ffff);
		send_request(OP_POP_REAR, 32'sh8000_0000);
	endtask

	task automatic test_fill_to_overflow();
		send_request(OP_PUSH_REAR, 32'sh8000_0000);
		send_request(OP_PUSH_FRONT, 32'sh7fff_ffff);
		send_request(OP_PUSH_REAR, '0);
		send_request(OP_PUSH_FRONT, -32'sd1);
		for (int i = 0; i < DEPTH - 4; i++) begin
			send_request(i[0] ? op_t'(OP_PUSH_FRONT) : op_t'(OP_PUSH_REAR), $urandom);
		end
		send_request(OP_PUSH_REAR, 32'sh1234_5678);
		send_request(OP_PUSH_FRONT, 32'sh7654_3210);
	endtask

	task automatic test_pop_both_ends();
		send_request(OP_POP_FRONT, -32'sd1);
		send_request(OP_POP_REAR, '0);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_REAR, -32'sd1);
	endtask

	task automatic test_random_walk(int count, int unsigned push_pct);
		for (int i = 0; i < count; i++) begin
			send_request(pick_op(push_pct), pick_word());
		end
	endtask

	task automatic test_burst(int count);
		wait_results_drained();
		idling_on = 1'b0;
		test_random_walk(count, 50);
		wait_results_drained();
		idling_on = 1'b1;
	endtask

	task automatic test_backpressure(int count);
		ready_hold_left = 80;
		test_random_walk(count, 60);
		wait_results_drained();
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected response popped_value %0d status %0d count %0d",
						$time, rsp_ch.popped_value, rsp_ch.status, rsp_ch.entry_count);
					error_count++;
				end else begin
					deq_result_t want;
					want = pending_results.pop_front();
					if (rsp_ch.popped_value !== want.popped_value) begin
						$display("%0t: popped_value expected %0d actual %0d", $time,
							want.popped_value, rsp_ch.popped_value);
						error_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d", $time,
							want.entry_count, rsp_ch.entry_count);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (ready_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				ready_hold_left--;
			end else begin
				rsp_ch.ready <= !idling_on || ($urandom_range(99) >= 18);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		error_count     = 0;
		idling_on       = 1'b1;
		ready_hold_left = 0;
		shadow_head     = 0;
		shadow_count    = 0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_PUSH_REAR;
		req_ch.value     <= '0;
		rsp_ch.ready     <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_fill_to_overflow();
		test_pop_both_ends();
		test_random_walk(150, 75);
		test_backpressure(40);
		test_random_walk(150, 25);
		test_burst(60);
		test_random_walk(150, 50);

		wait_results_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/deq_pkg.sv
src/deq_if.sv
src/deq_ram.sv
src/double_ended_queue_core.sv
test/tb_double_ended_queue_core.sv
